/* rtl/cgvs_pkg.sv */
`default_nettype none
package cgvs_pkg;

    localparam int SQRT_STEPS = 64;
    localparam int DIV_STEPS  = 64;

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [0:0]  CFG_GRAV   = 1'b0;
    localparam logic [0:0]  CFG_STEP   = 1'b1;
    localparam logic [31:0] STEP_RESET = 32'd65536;

    typedef logic [2:0][63:0]  t_vec3;
    typedef logic [2:0][127:0] t_wide3;

    typedef struct packed {
        t_vec3        np;
        t_vec3        vel;
        t_vec3        acc;
        t_wide3       mm;
        logic [127:0] r2;
        logic         zero;
        logic         sat;
    } t_side;

endpackage
`default_nettype wire

/* rtl/central_gravity_verlet_step_unit.sv */
`default_nettype none
// Channel  Handshake                     Payload
// input    start (busy always low)       i_pos_*, i_vel_*, i_acc_*
// config   i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
// result   o_done, one-cycle strobe      o_new_pos_*, o_new_vel_*, o_new_acc_*, flags
//
// One body enters per cycle; result words leave in the order the bodies entered.
// Each body passes through the 64-step square root pipe and the 64-step divider pipe.
// Reset clears valid bits and loads grav_param 0, time_step 1.0.
// The pipe never stalls: results must be taken when o_done is high.
module central_gravity_verlet_step_unit import cgvs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic signed [63:0] i_pos_x,
    input  logic signed [63:0] i_pos_y,
    input  logic signed [63:0] i_pos_z,
    input  logic signed [63:0] i_vel_x,
    input  logic signed [63:0] i_vel_y,
    input  logic signed [63:0] i_vel_z,
    input  logic signed [63:0] i_acc_x,
    input  logic signed [63:0] i_acc_y,
    input  logic signed [63:0] i_acc_z,
    output logic        o_done,
    output logic signed [63:0] o_new_pos_x,
    output logic signed [63:0] o_new_pos_y,
    output logic signed [63:0] o_new_pos_z,
    output logic signed [63:0] o_new_vel_x,
    output logic signed [63:0] o_new_vel_y,
    output logic signed [63:0] o_new_vel_z,
    output logic signed [63:0] o_new_acc_x,
    output logic signed [63:0] o_new_acc_y,
    output logic signed [63:0] o_new_acc_z,
    output logic        o_zero_distance,
    output logic        o_saturated
);

    logic [63:0] r_grav_param;
    logic [31:0] r_time_step;
    logic [63:0] r_dt2;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav_param <= '0;
            r_time_step  <= STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRAV: r_grav_param <= i_cfg_data;
                CFG_STEP: r_time_step  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
        r_dt2 <= r_time_step * r_time_step;
    end

    // input capture
    logic  r_a_vld;
    t_side r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
        r_a_side.np[0]  <= i_pos_x;
        r_a_side.np[1]  <= i_pos_y;
        r_a_side.np[2]  <= i_pos_z;
        r_a_side.vel[0] <= i_vel_x;
        r_a_side.vel[1] <= i_vel_y;
        r_a_side.vel[2] <= i_vel_z;
        r_a_side.acc[0] <= i_acc_x;
        r_a_side.acc[1] <= i_acc_y;
        r_a_side.acc[2] <= i_acc_z;
        r_a_side.mm     <= '0;
        r_a_side.r2     <= '0;
        r_a_side.zero   <= 1'b0;
        r_a_side.sat    <= 1'b0;
    end

    // position partial products
    logic               r_b_vld;
    t_side              r_b_side;
    logic signed [64:0] r_b_vh   [3];
    logic        [63:0] r_b_vl   [3];
    logic signed [64:0] r_b_ahdh [3];
    logic signed [64:0] r_b_ahdl [3];
    logic        [63:0] r_b_aldh [3];
    logic        [63:0] r_b_aldl [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_side <= r_a_side;
        for (int i = 0; i < 3; i++) begin
            r_b_vh[i]   <= $signed(r_a_side.vel[i][63:32]) * $signed({1'b0, r_time_step});
            r_b_vl[i]   <= r_a_side.vel[i][31:0] * r_time_step;
            r_b_ahdh[i] <= $signed(r_a_side.acc[i][63:32]) * $signed({1'b0, r_dt2[63:32]});
            r_b_ahdl[i] <= $signed(r_a_side.acc[i][63:32]) * $signed({1'b0, r_dt2[31:0]});
            r_b_aldh[i] <= r_a_side.acc[i][31:0] * r_dt2[63:32];
            r_b_aldl[i] <= r_a_side.acc[i][31:0] * r_dt2[31:0];
        end
    end

    // v*dt and a*dt^2
    logic                r_c_vld;
    t_side               r_c_side;
    logic signed [95:0]  r_c_vdt [3];
    logic signed [127:0] r_c_adt [3];
    logic signed [95:0]  w_vh    [3];
    logic signed [95:0]  w_vl    [3];
    logic signed [127:0] w_ahdh  [3];
    logic signed [127:0] w_ahdl  [3];
    logic signed [127:0] w_aldh  [3];
    logic signed [127:0] w_aldl  [3];
    logic signed [95:0]  n_c_vdt [3];
    logic signed [127:0] n_c_adt [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_vh[i]    = r_b_vh[i];
            w_vl[i]    = {32'b0, r_b_vl[i]};
            w_ahdh[i]  = r_b_ahdh[i];
            w_ahdl[i]  = r_b_ahdl[i];
            w_aldh[i]  = {64'b0, r_b_aldh[i]};
            w_aldl[i]  = {64'b0, r_b_aldl[i]};
            n_c_vdt[i] = (w_vh[i] <<< 32) + w_vl[i];
            n_c_adt[i] = (w_ahdh[i] <<< 64) + (w_ahdl[i] <<< 32) + (w_aldh[i] <<< 32)
                       + w_aldl[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_side <= r_b_side;
        for (int i = 0; i < 3; i++) begin
            r_c_vdt[i] <= n_c_vdt[i];
            r_c_adt[i] <= n_c_adt[i];
        end
    end

    // new position, round and clamp
    logic                r_d_vld;
    t_side               r_d_side;
    t_side               n_d_side;
    logic signed [143:0] w_p   [3];
    logic signed [143:0] w_vdt [3];
    logic signed [143:0] w_adt [3];
    logic signed [143:0] w_t   [3];
    logic                w_fit [3];

    always_comb begin
        n_d_side = r_c_side;
        for (int i = 0; i < 3; i++) begin
            w_p[i]   = $signed(r_c_side.np[i]);
            w_vdt[i] = r_c_vdt[i];
            w_adt[i] = r_c_adt[i];
            w_t[i]   = (w_p[i] <<< 61) + (w_vdt[i] <<< 45) + w_adt[i]
                     + (144'sd1 <<< 60);
            w_fit[i] = (w_t[i][143:124] == '0) || (w_t[i][143:124] == '1);
            if (w_fit[i]) begin
                n_d_side.np[i] = w_t[i][124:61];
            end else begin
                n_d_side.np[i] = w_t[i][143] ? SIGN64 : MAX64;
                n_d_side.sat   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_side <= n_d_side;
    end

    // origin test and magnitudes
    logic        r_e_vld;
    t_side       r_e_side;
    t_side       n_e_side;
    logic [63:0] r_e_mag [3];

    always_comb begin
        n_e_side      = r_d_side;
        n_e_side.zero = r_d_side.np == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
        r_e_side <= n_e_side;
        for (int i = 0; i < 3; i++) begin
            r_e_mag[i] <= r_d_side.np[i][63] ? 64'(64'd0 - r_d_side.np[i]) : r_d_side.np[i];
        end
    end

    // square and mu*|p| partial products
    logic        r_f_vld;
    t_side       r_f_side;
    logic [63:0] r_f_hh  [3];
    logic [63:0] r_f_hl  [3];
    logic [63:0] r_f_ll  [3];
    logic [63:0] r_f_uhh [3];
    logic [63:0] r_f_uhl [3];
    logic [63:0] r_f_ulh [3];
    logic [63:0] r_f_ull [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= r_e_vld;
        end
        r_f_side <= r_e_side;
        for (int i = 0; i < 3; i++) begin
            r_f_hh[i]  <= r_e_mag[i][63:32] * r_e_mag[i][63:32];
            r_f_hl[i]  <= r_e_mag[i][63:32] * r_e_mag[i][31:0];
            r_f_ll[i]  <= r_e_mag[i][31:0] * r_e_mag[i][31:0];
            r_f_uhh[i] <= r_grav_param[63:32] * r_e_mag[i][63:32];
            r_f_uhl[i] <= r_grav_param[63:32] * r_e_mag[i][31:0];
            r_f_ulh[i] <= r_grav_param[31:0] * r_e_mag[i][63:32];
            r_f_ull[i] <= r_grav_param[31:0] * r_e_mag[i][31:0];
        end
    end

    // squares and mu*|p|
    logic         r_g_vld;
    t_side        r_g_side;
    t_side        n_g_side;
    logic [127:0] r_g_sq [3];

    always_comb begin
        n_g_side = r_f_side;
        for (int i = 0; i < 3; i++) begin
            n_g_side.mm[i] = (128'(r_f_uhh[i]) << 64) + (128'(r_f_uhl[i]) << 32)
                           + (128'(r_f_ulh[i]) << 32) + 128'(r_f_ull[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
        r_g_side <= n_g_side;
        for (int i = 0; i < 3; i++) begin
            r_g_sq[i] <= (128'(r_f_hh[i]) << 64) + (128'(r_f_hl[i]) << 33) + 128'(r_f_ll[i]);
        end
    end

    // r^2
    logic  r_h_vld;
    t_side r_h_side;
    t_side n_h_side;

    always_comb begin
        n_h_side    = r_g_side;
        n_h_side.r2 = r_g_sq[0] + r_g_sq[1] + r_g_sq[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
        end else begin
            r_h_vld <= r_g_vld;
        end
        r_h_side <= n_h_side;
    end

    logic        q_vld;
    logic [63:0] q_root;
    t_side       q_side;

    cgvs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_h_vld),
        .i_rad   (r_h_side.r2),
        .i_side  (r_h_side),
        .o_valid (q_vld),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    // r^2 * r partial products
    logic        r_i_vld;
    t_side       r_i_side;
    logic [63:0] r_i_pp [4][2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld <= 1'b0;
        end else begin
            r_i_vld <= q_vld;
        end
        r_i_side <= q_side;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 2; k++) begin
                r_i_pp[c][k] <= q_side.r2[32*c +: 32] * q_root[32*k +: 32];
            end
        end
    end

    logic         r_j_vld;
    t_side        r_j_side;
    logic [159:0] r_j_part [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_vld <= 1'b0;
        end else begin
            r_j_vld <= r_i_vld;
        end
        r_j_side <= r_i_side;
        for (int k = 0; k < 2; k++) begin
            r_j_part[k] <= 160'(r_i_pp[0][k]) + (160'(r_i_pp[1][k]) << 32)
                         + (160'(r_i_pp[2][k]) << 64) + (160'(r_i_pp[3][k]) << 96);
        end
    end

    logic         r_k_vld;
    t_side        r_k_side;
    logic [191:0] r_k_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
        end else begin
            r_k_vld <= r_j_vld;
        end
        r_k_side <= r_j_side;
        r_k_den  <= 192'(r_j_part[0]) + (192'(r_j_part[1]) << 32);
    end

    logic       d_vld;
    t_vec3      d_quot;
    logic [2:0] d_over;
    t_side      d_side;

    cgvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_k_vld),
        .i_den   (r_k_den),
        .i_side  (r_k_side),
        .o_valid (d_vld),
        .o_quot  (d_quot),
        .o_over  (d_over),
        .o_side  (d_side)
    );

    // signed, clamped acceleration
    logic  r_l_vld;
    t_side r_l_side;
    t_vec3 r_l_na;
    t_side n_l_side;
    t_vec3 n_l_na;

    always_comb begin
        n_l_side = d_side;
        for (int i = 0; i < 3; i++) begin
            if (d_side.zero) begin
                n_l_na[i] = '0;
            end else if (d_side.np[i][63]) begin
                if (d_over[i] || d_quot[i][63]) begin
                    n_l_na[i]     = MAX64;
                    n_l_side.sat = 1'b1;
                end else begin
                    n_l_na[i] = d_quot[i];
                end
            end else if (d_over[i] || (d_quot[i] > SIGN64)) begin
                n_l_na[i]    = SIGN64;
                n_l_side.sat = 1'b1;
            end else begin
                n_l_na[i] = 64'(64'd0 - d_quot[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_vld <= 1'b0;
        end else begin
            r_l_vld <= d_vld;
        end
        r_l_side <= n_l_side;
        r_l_na   <= n_l_na;
    end

    // a_old + a_new
    logic               r_m_vld;
    t_side              r_m_side;
    t_vec3              r_m_na;
    logic signed [64:0] r_m_s [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= r_l_vld;
        end
        r_m_side <= r_l_side;
        r_m_na   <= r_l_na;
        for (int i = 0; i < 3; i++) begin
            r_m_s[i] <= $signed(r_l_side.acc[i]) + $signed(r_l_na[i]);
        end
    end

    // (a_old + a_new) * dt partial products
    logic               r_n_vld;
    t_side              r_n_side;
    t_vec3              r_n_na;
    logic signed [65:0] r_n_ph [3];
    logic        [63:0] r_n_pl [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
        end else begin
            r_n_vld <= r_m_vld;
        end
        r_n_side <= r_m_side;
        r_n_na   <= r_m_na;
        for (int i = 0; i < 3; i++) begin
            r_n_ph[i] <= $signed(r_m_s[i][64:32]) * $signed({1'b0, r_time_step});
            r_n_pl[i] <= r_m_s[i][31:0] * r_time_step;
        end
    end

    // new velocity and output register
    logic                r_o_vld;
    t_vec3               r_o_np;
    t_vec3               r_o_nv;
    t_vec3               r_o_na;
    logic                r_o_zero;
    logic                r_o_sat;
    logic signed [111:0] w_v   [3];
    logic signed [111:0] w_ph  [3];
    logic signed [111:0] w_pl  [3];
    logic signed [111:0] w_tv  [3];
    logic                w_vfit[3];
    t_vec3               n_o_nv;
    logic                n_o_sat;

    always_comb begin
        n_o_sat = r_n_side.sat;
        for (int i = 0; i < 3; i++) begin
            w_v[i]    = $signed(r_n_side.vel[i]);
            w_ph[i]   = r_n_ph[i];
            w_pl[i]   = {48'b0, r_n_pl[i]};
            w_tv[i]   = (w_v[i] <<< 45) + (w_ph[i] <<< 32) + w_pl[i] + (112'sd1 <<< 44);
            w_vfit[i] = (w_tv[i][111:108] == '0) || (w_tv[i][111:108] == '1);
            if (w_vfit[i]) begin
                n_o_nv[i] = w_tv[i][108:45];
            end else begin
                n_o_nv[i] = w_tv[i][111] ? SIGN64 : MAX64;
                n_o_sat   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_n_vld;
        end
        r_o_np   <= r_n_side.np;
        r_o_nv   <= n_o_nv;
        r_o_na   <= r_n_na;
        r_o_zero <= r_n_side.zero;
        r_o_sat  <= n_o_sat;
    end

    assign o_done          = r_o_vld;
    assign o_new_pos_x     = r_o_np[0];
    assign o_new_pos_y     = r_o_np[1];
    assign o_new_pos_z     = r_o_np[2];
    assign o_new_vel_x     = r_o_nv[0];
    assign o_new_vel_y     = r_o_nv[1];
    assign o_new_vel_z     = r_o_nv[2];
    assign o_new_acc_x     = r_o_na[0];
    assign o_new_acc_y     = r_o_na[1];
    assign o_new_acc_z     = r_o_na[2];
    assign o_zero_distance = r_o_zero;
    assign o_saturated     = r_o_sat;

endmodule
`default_nettype wire

/* rtl/cgvs_isqrt.sv */
`default_nettype none
module cgvs_isqrt import cgvs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [127:0] i_rad,
    input  t_side        i_side,
    output logic         o_valid,
    output logic [63:0]  o_root,
    output t_side        o_side
);

    logic         r_vld  [SQRT_STEPS];
    logic [127:0] r_op   [SQRT_STEPS];
    logic [127:0] r_res  [SQRT_STEPS];
    t_side        r_side [SQRT_STEPS];

    generate
        for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
            localparam logic [127:0] ONE = 128'(1) << (126 - 2 * g);
            logic         vld_in;
            logic [127:0] op_in;
            logic [127:0] res_in;
            t_side        side_in;
            logic [127:0] trial;
            logic [127:0] n_op;
            logic [127:0] n_res;

            if (g == 0) begin : g_first
                assign vld_in  = i_valid;
                assign op_in   = i_rad;
                assign res_in  = '0;
                assign side_in = i_side;
            end else begin : g_next
                assign vld_in  = r_vld[g-1];
                assign op_in   = r_op[g-1];
                assign res_in  = r_res[g-1];
                assign side_in = r_side[g-1];
            end

            always_comb begin
                trial = res_in + ONE;
                if (op_in >= trial) begin
                    n_op  = op_in - trial;
                    n_res = (res_in >> 1) + ONE;
                end else begin
                    n_op  = op_in;
                    n_res = res_in >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else begin
                    r_vld[g] <= vld_in;
                end
                r_op[g]   <= n_op;
                r_res[g]  <= n_res;
                r_side[g] <= side_in;
            end
        end
    endgenerate

    assign o_valid = r_vld[SQRT_STEPS-1];
    assign o_root  = r_res[SQRT_STEPS-1][63:0];
    assign o_side  = r_side[SQRT_STEPS-1];

endmodule
`default_nettype wire

/* rtl/cgvs_div.sv */
`default_nettype none
module cgvs_div import cgvs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [191:0] i_den,
    input  t_side        i_side,
    output logic         o_valid,
    output t_vec3        o_quot,
    output logic [2:0]   o_over,
    output t_side        o_side
);

    typedef logic [2:0][191:0] t_rem3;

    logic         r_p_vld;
    logic [191:0] r_p_den;
    t_rem3        r_p_rem;
    logic [2:0]   r_p_over;
    t_side        r_p_side;

    logic         r_vld  [DIV_STEPS];
    logic [191:0] r_den  [DIV_STEPS];
    t_rem3        r_rem  [DIV_STEPS];
    t_vec3        r_quot [DIV_STEPS];
    logic [2:0]   r_over [DIV_STEPS];
    t_side        r_side [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_valid;
        end
        r_p_den  <= i_den;
        r_p_side <= i_side;
        for (int i = 0; i < 3; i++) begin
            r_p_over[i] <= i_den <= {64'b0, i_side.mm[i]};
            r_p_rem[i]  <= {64'b0, i_side.mm[i]};
        end
    end

    generate
        for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
            logic         vld_in;
            logic [191:0] den_in;
            t_rem3        rem_in;
            t_vec3        quot_in;
            logic [2:0]   over_in;
            t_side        side_in;
            logic [192:0] shl [3];
            t_rem3        n_rem;
            t_vec3        n_quot;

            if (g == 0) begin : g_first
                assign vld_in  = r_p_vld;
                assign den_in  = r_p_den;
                assign rem_in  = r_p_rem;
                assign quot_in = '0;
                assign over_in = r_p_over;
                assign side_in = r_p_side;
            end else begin : g_next
                assign vld_in  = r_vld[g-1];
                assign den_in  = r_den[g-1];
                assign rem_in  = r_rem[g-1];
                assign quot_in = r_quot[g-1];
                assign over_in = r_over[g-1];
                assign side_in = r_side[g-1];
            end

            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    shl[i] = {rem_in[i], 1'b0};
                    if (shl[i] >= {1'b0, den_in}) begin
                        n_rem[i]  = 192'(shl[i] - {1'b0, den_in});
                        n_quot[i] = {quot_in[i][62:0], 1'b1};
                    end else begin
                        n_rem[i]  = shl[i][191:0];
                        n_quot[i] = {quot_in[i][62:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else begin
                    r_vld[g] <= vld_in;
                end
                r_den[g]  <= den_in;
                r_rem[g]  <= n_rem;
                r_quot[g] <= n_quot;
                r_over[g] <= over_in;
                r_side[g] <= side_in;
            end
        end
    endgenerate

    assign o_valid = r_vld[DIV_STEPS-1];
    assign o_quot  = r_quot[DIV_STEPS-1];
    assign o_over  = r_over[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];

endmodule
`default_nettype wire

/* bench/central_gravity_verlet_step_unit_tb.sv */
`timescale 1ns / 100ps
module central_gravity_verlet_step_unit_tb;
    import cgvs_pkg::*;

    typedef logic signed [255:0] s256;
    typedef logic [255:0] u256;

    typedef struct {
        t_vec3 np;
        t_vec3 nv;
        t_vec3 na;
        logic  zero;
        logic  sat;
    } t_body_result;

    typedef struct {
        t_vec3        pos;
        t_vec3        vel;
        t_vec3        acc;
        logic         has_exp;
        t_body_result exp;
    } t_body_row;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [0:0] i_cfg_index;
    logic [63:0] i_cfg_data;
    t_vec3 pos_in, vel_in, acc_in;
    logic o_done;
    logic signed [63:0] o_new_pos_x, o_new_pos_y, o_new_pos_z;
    logic signed [63:0] o_new_vel_x, o_new_vel_y, o_new_vel_z;
    logic signed [63:0] o_new_acc_x, o_new_acc_y, o_new_acc_z;
    logic o_zero_distance, o_saturated;

    logic         row_has_exp;
    t_body_result row_exp;

    logic [63:0] model_mu;
    logic [31:0] model_dt;
    t_body_result pending_results[$];
    int errors;
    int cycles;
    int bodies_checked;
    int zero_hits;
    int sat_hits;
    bit idle_on;

    central_gravity_verlet_step_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_pos_x(pos_in[0]), .i_pos_y(pos_in[1]), .i_pos_z(pos_in[2]),
        .i_vel_x(vel_in[0]), .i_vel_y(vel_in[1]), .i_vel_z(vel_in[2]),
        .i_acc_x(acc_in[0]), .i_acc_y(acc_in[1]), .i_acc_z(acc_in[2]),
        .o_done(o_done),
        .o_new_pos_x(o_new_pos_x), .o_new_pos_y(o_new_pos_y), .o_new_pos_z(o_new_pos_z),
        .o_new_vel_x(o_new_vel_x), .o_new_vel_y(o_new_vel_y), .o_new_vel_z(o_new_vel_z),
        .o_new_acc_x(o_new_acc_x), .o_new_acc_y(o_new_acc_y), .o_new_acc_z(o_new_acc_z),
        .o_zero_distance(o_zero_distance), .o_saturated(o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] clamp64(input s256 x, inout logic sat);
        s256 hi, lo;
        hi = s256'({192'b0, MAX64});
        lo = -(s256'(1) <<< 63);
        if (x > hi) begin
            sat = 1'b1;
            return MAX64;
        end
        if (x < lo) begin
            sat = 1'b1;
            return SIGN64;
        end
        return x[63:0];
    endfunction

    function automatic logic [63:0] root_floor(input u256 v);
        logic [63:0] res, t;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            t = res | (64'd1 << b);
            if (u256'(t) * u256'(t) <= v) res = t;
        end
        return res;
    endfunction

    function automatic logic [63:0] pull_axis(input logic [63:0] p, input u256 den,
                                              input logic [63:0] mu, inout logic sat);
        logic [63:0] mag;
        u256 num, q;
        logic over;
        mag = p[63] ? (64'd0 - p) : p;
        num = (u256'(mu) * u256'(mag)) << 64;
        over = (den << 64) <= num;
        q = over ? '0 : num / den;
        if (p[63]) begin
            if (over || q > u256'(MAX64)) begin
                sat = 1'b1;
                return MAX64;
            end
            return q[63:0];
        end
        if (over || q > u256'(SIGN64)) begin
            sat = 1'b1;
            return SIGN64;
        end
        return 64'd0 - q[63:0];
    endfunction

    function automatic t_body_result verlet_advance(input t_vec3 p, input t_vec3 v,
                                                    input t_vec3 a, input logic [63:0] mu,
                                                    input logic [31:0] dt);
        t_body_result r;
        s256 dts, dt2, t, s;
        u256 r2, den;
        logic sat;
        sat = 1'b0;
        dts = s256'({224'b0, dt});
        dt2 = dts * dts;
        for (int i = 0; i < 3; i++) begin
            t = (s256'($signed(p[i])) <<< 61) + ((s256'($signed(v[i])) * dts) <<< 45)
                + s256'($signed(a[i])) * dt2 + (s256'(1) <<< 60);
            r.np[i] = clamp64(t >>> 61, sat);
        end
        r.zero = (r.np[0] | r.np[1] | r.np[2]) == 64'd0;
        if (r.zero) begin
            r.na = '0;
        end else begin
            r2 = '0;
            for (int i = 0; i < 3; i++)
                r2 = r2 + u256'(s256'($signed(r.np[i])) * s256'($signed(r.np[i])));
            den = r2 * u256'(root_floor(r2));
            for (int i = 0; i < 3; i++) r.na[i] = pull_axis(r.np[i], den, mu, sat);
        end
        for (int i = 0; i < 3; i++) begin
            s = s256'($signed(a[i])) + s256'($signed(r.na[i]));
            t = (s256'($signed(v[i])) <<< 45) + s * dts + (s256'(1) <<< 44);
            r.nv[i] = clamp64(t >>> 45, sat);
        end
        r.sat = sat;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_body_result e;
        logic [63:0] got[11];
        logic [63:0] want[11];
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: result word with nothing expected", $time);
                end else begin
                    e = pending_results.pop_front();
                    got = '{o_new_pos_x, o_new_pos_y, o_new_pos_z, o_new_vel_x,
                            o_new_vel_y, o_new_vel_z, o_new_acc_x, o_new_acc_y,
                            o_new_acc_z, {63'b0, o_zero_distance}, {63'b0, o_saturated}};
                    want = '{e.np[0], e.np[1], e.np[2], e.nv[0], e.nv[1], e.nv[2],
                             e.na[0], e.na[1], e.na[2], {63'b0, e.zero}, {63'b0, e.sat}};
                    for (int k = 0; k < 11; k++)
                        if (got[k] !== want[k]) begin
                            errors++;
                            $display("%0t: field %0d expected %h got %h",
                                     $time, k, want[k], got[k]);
                        end
                    bodies_checked++;
                    zero_hits += e.zero;
                    sat_hits += e.sat;
                end
            end
            if (start && !busy)
                pending_results.push_back(row_has_exp ? row_exp :
                    verlet_advance(pos_in, vel_in, acc_in, model_mu, model_dt));
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_GRAV) model_mu = i_cfg_data;
                else if (i_cfg_index == CFG_STEP) model_dt = i_cfg_data[31:0];
            end
        end
    end

    task automatic send_body(input t_body_row row);
        while (idle_on && $urandom_range(99) < 23) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        pos_in = row.pos;
        vel_in = row.vel;
        acc_in = row.acc;
        row_has_exp = row.has_exp;
        row_exp = row.exp;
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [63:0] data);
        while ($urandom_range(99) < 23) @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain;
        start = 1'b0;
        row_has_exp = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_scaled(input int lo, input int hi);
        return $signed(rand64()) >>> $urandom_range(hi, lo);
    endfunction

    function automatic t_body_row random_body;
        t_body_row b;
        int pick;
        b.has_exp = 1'b0;
        b.exp = '{default: '0};
        pick = $urandom_range(99);
        for (int i = 0; i < 3; i++) begin
            if (pick < 70) begin
                b.pos[i] = rand_scaled(8, 40);
                b.vel[i] = rand_scaled(20, 50);
                b.acc[i] = rand_scaled(0, 30);
            end else if (pick < 95) begin
                b.pos[i] = rand64();
                b.vel[i] = rand64();
                b.acc[i] = rand64();
            end else begin
                b.pos[i] = '0;
                b.vel[i] = '0;
                b.acc[i] = ($urandom_range(1) != 0) ? '0 : rand_scaled(50, 63);
            end
        end
        return b;
    endfunction

    t_body_row rows[$];
    logic [63:0] mu_set[6];
    logic [31:0] dt_set[6];

    initial begin
        t_body_row b;
        t_body_result quiet;
        errors = 0;
        cycles = 0;
        bodies_checked = 0;
        zero_hits = 0;
        sat_hits = 0;
        idle_on = 1'b1;
        model_mu = '0;
        model_dt = STEP_RESET;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_GRAV;
        i_cfg_data = '0;
        pos_in = '0;
        vel_in = '0;
        acc_in = '0;
        row_has_exp = 1'b0;
        row_exp = '{default: '0};
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        quiet = '{np: '0, nv: '0, na: '0, zero: 1'b1, sat: 1'b0};
        rows.push_back('{'0, '0, '0, 1'b1, quiet});
        quiet = '{np: '{MAX64, MAX64, MAX64}, nv: '0, na: '0, zero: 1'b0, sat: 1'b0};
        rows.push_back('{'{MAX64, MAX64, MAX64}, '0, '0, 1'b1, quiet});
        quiet = '{np: '{SIGN64, SIGN64, SIGN64}, nv: '0, na: '0, zero: 1'b0, sat: 1'b0};
        rows.push_back('{'{SIGN64, SIGN64, SIGN64}, '0, '0, 1'b1, quiet});
        quiet = '{np: '{MAX64, MAX64, MAX64}, nv: '{MAX64, MAX64, MAX64}, na: '0,
                  zero: 1'b0, sat: 1'b1};
        rows.push_back('{'{MAX64, MAX64, MAX64}, '{MAX64, MAX64, MAX64},
                         '{MAX64, MAX64, MAX64}, 1'b1, quiet});
        rows.push_back('{'{SIGN64, SIGN64, SIGN64}, '{SIGN64, SIGN64, SIGN64},
                         '{SIGN64, SIGN64, SIGN64}, 1'b0, quiet});
        rows.push_back('{'{64'd1, 64'd0, 64'd0}, '0, '0, 1'b0, quiet});
        rows.push_back('{'{64'd0, 64'd0, -64'sd1}, '0, '0, 1'b0, quiet});
        rows.push_back('{'{64'h1_0000_0000, 64'd0, 64'd0}, '{64'd0, 64'h1_0000_0000, 64'd0},
                         '{-64'sh1000_0000_0000_0000, 64'd0, 64'd0}, 1'b0, quiet});
        rows.push_back('{'{64'h1_0000_0000, 64'd0, 64'd0}, '{-64'sh1_0000_0000, 64'd0, 64'd0},
                         '0, 1'b0, quiet});
        rows.push_back('{'{64'd0, 64'd0, 64'd1}, '{64'd0, 64'd0, -64'sd1}, '0, 1'b0, quiet});

        mu_set = '{64'd0, 64'h1000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'h0000_0400_0000_0000, rand64(), 64'd1};
        dt_set = '{STEP_RESET, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0100,
                   $urandom, 32'd0};

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain();
                write_reg(CFG_GRAV, mu_set[ph]);
                write_reg(CFG_STEP, {$urandom, dt_set[ph]});
            end
            foreach (rows[k]) begin
                b = rows[k];
                if (ph > 0) b.has_exp = 1'b0;
                send_body(b);
            end
            for (int n = 0; n < 290; n++) begin
                idle_on = !(ph == 2 && n > 60 && n < 260);
                send_body(random_body());
            end
            idle_on = 1'b1;
        end
        drain();

        $display("checked %0d bodies over 6 register settings", bodies_checked);
        $display("%0d at the origin, %0d clamped", zero_hits, sat_hits);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
